/* src/deq_pkg.sv */
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  // Reported in place of a word that does not exist.
  localparam logic [WORD_W-1:0] WORD_NONE = '1;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4,
    KIND_REVERSE    = 3'd5
  } deq_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } deq_state_t;

  typedef struct packed {
    logic                push_dropped;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
    logic [WORD_W-1:0]   back_value;
    logic [WORD_W-1:0]   front_value;
    logic                popped_ok;
    logic [WORD_W-1:0]   popped_value;
  } deq_res_t;

endpackage

/* src/deq_store.sv */
// Word store: one write port, one read port with registered read data.
module deq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [deq_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [deq_pkg::WORD_W-1:0] rd_data
);
  import deq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/deq_ctrl.sv */
// Queue control: ring pointers, end-word cache, store access and result forming.
module deq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_kind,
  input  logic [deq_pkg::WORD_W-1:0] in_value,
  input  logic                       out_free,
  output logic                       res_load,
  output deq_pkg::deq_res_t          res,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [deq_pkg::WORD_W-1:0] wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [deq_pkg::WORD_W-1:0] rd_data
);
  import deq_pkg::*;

  deq_state_t        state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              rev_r, rev_nxt;
  logic [WORD_W-1:0] hword_r, hword_nxt;   // word at the physical head slot
  logic [WORD_W-1:0] tword_r, tword_nxt;   // word at the physical tail slot
  logic [WORD_W-1:0] popped_r, popped_nxt;
  logic              fill_head_r, fill_head_nxt;

  logic              accept;
  logic              fill_req;
  logic [WORD_W-1:0] pop_val;
  logic              pop_ok;
  logic              dropped;
  deq_kind_t         kind;

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] i, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(i) + (CW+1)'(n);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign kind   = deq_kind_t'(in_kind);
  assign accept = in_valid && in_ready;

  // Pointer, cache and store access.
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    hword_nxt     = hword_r;
    tword_nxt     = tword_r;
    popped_nxt    = popped_r;
    fill_head_nxt = fill_head_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_value;
    rd_en         = 1'b0;
    rd_addr       = '0;
    pop_val       = WORD_NONE;
    pop_ok        = 1'b0;
    dropped       = 1'b0;

    if (state_r == ST_FILL) begin
      pop_val = popped_r;
      pop_ok  = 1'b1;
      if (fill_head_r) begin
        hword_nxt = rd_data;
      end else begin
        tword_nxt = rd_data;
      end
    end else if (accept) begin
      unique case (kind) inside
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (count_r == CW'(DEPTH)) begin
            dropped = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
            wr_en     = 1'b1;
            if ((kind == KIND_PUSH_FRONT) != rev_r) begin
              head_nxt  = slot_dec(head_r);
              wr_addr   = slot_dec(head_r);
              hword_nxt = in_value;
              if (count_r == '0) begin
                tword_nxt = in_value;
              end
            end else begin
              wr_addr   = slot_add(head_r, count_r);
              tword_nxt = in_value;
              if (count_r == '0) begin
                hword_nxt = in_value;
              end
            end
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (count_r != '0) begin
            pop_ok        = 1'b1;
            count_nxt     = count_r - 1'b1;
            fill_head_nxt = (kind == KIND_POP_FRONT) != rev_r;
            if ((kind == KIND_POP_FRONT) != rev_r) begin
              pop_val  = hword_r;
              head_nxt = slot_add(head_r, CW'(1));
              if (count_r == CW'(2)) begin
                hword_nxt = tword_r;
              end else if (count_r > CW'(2)) begin
                rd_en   = 1'b1;
                rd_addr = slot_add(head_r, CW'(1));
              end
            end else begin
              pop_val = tword_r;
              if (count_r == CW'(2)) begin
                tword_nxt = hword_r;
              end else if (count_r > CW'(2)) begin
                rd_en   = 1'b1;
                rd_addr = slot_add(head_r, count_r - CW'(2));
              end
            end
            popped_nxt = pop_val;
          end
        end
        KIND_CLEAR: begin
          count_nxt = '0;
        end
        KIND_REVERSE: begin
          rev_nxt = ~rev_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign fill_req = rd_en;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && fill_req) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // FSM outputs.
  always_comb begin
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        res_load = accept && !fill_req;
      end
      ST_FILL: begin
        res_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result seen after the step.
  always_comb begin
    res.popped_value = pop_val;
    res.popped_ok    = pop_ok;
    res.push_dropped = dropped;
    res.entry_count  = COUNT_W'(count_nxt);
    res.is_empty     = (count_nxt == '0);
    if (count_nxt == '0) begin
      res.front_value = WORD_NONE;
      res.back_value  = WORD_NONE;
    end else begin
      res.front_value = rev_nxt ? tword_nxt : hword_nxt;
      res.back_value  = rev_nxt ? hword_nxt : tword_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      fill_head_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      fill_head_r <= fill_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hword_r  <= hword_nxt;
    tword_r  <= tword_nxt;
    popped_r <= popped_nxt;
  end

endmodule

/* src/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: store, control and result register.
//
// Bounded deque of DEPTH signed 32-bit words kept in a ring buffer.
// Input channel (in_*): one beat per operation. in_tuser carries the kind
// (push front/back, pop front/back, clear, reverse; codes 6 and 7 do nothing),
// in_tdata the word to push. Result channel (out_*): exactly one beat per
// input beat, in order, with the popped word, the front and back words,
// the count and the empty and push-dropped flags as seen after the step.
// The result register loads as the input beat is taken. A pop
// that leaves two or more words must fetch the new end word from the
// store (one read port, registered read data), so that result is loaded
// from the fill state after the read, and the input is closed meanwhile.
// Throughput: one item per cycle while the result slot is free, except for a refilling pop.
// The front and back words are cached in registers; the store only sees one
// write per push and one read per refilling pop.
// Reset clears the pointers, count and direction; the store keeps garbage,
// but only held slots are ever read. When the receiver stalls, the result
// register holds its beat and in_tready drops until the beat is taken.
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // [31:0] value, [39:32] zero pad
  input  logic [2:0]   in_tuser,   // [2:0] kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // [31:0] popped_value, [32] popped_ok,
                                   // [64:33] front_value, [96:65] back_value,
                                   // [101:97] entry_count, [102] is_empty,
                                   // [103] push_dropped
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  logic              res_load;
  deq_res_t          res;
  deq_res_t          res_r;
  logic              out_valid_r;
  logic              out_free;

  // Result slot is free when empty or its beat goes out this cycle.
  assign out_free = !out_valid_r || out_tready;

  deq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_kind (in_tuser),
    .in_value(in_tdata[WORD_W-1:0]),
    .out_free(out_free),
    .res_load(res_load),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  deq_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Output register: loads only when free, so a stalled beat holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

/* src/deq_checker.sv */
// Port-level checks for the double-ended queue unit, bound to the top level.
module deq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // A stalled result beat stays up and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // An empty queue reports no front and no back word.
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[102] |->
      out_tdata[64:33] == 32'hFFFF_FFFF && out_tdata[96:65] == 32'hFFFF_FFFF &&
      out_tdata[101:97] == 5'd0)
    else $error("empty queue shows words");

  // No pop, no popped word.
  a_pop_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("popped word without a pop");

  // A dropped push pops nothing.
  a_drop_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[103] |-> !out_tdata[32] && !out_tdata[102])
    else $error("dropped push with pop or empty queue");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* tb/sv/testbench.sv */
// Testbench for the double-ended queue unit: directed table plus random op stream, scoreboarded.
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  // Ring size under test; the predictor uses the same value.
  localparam int QDEPTH     = 16;
  // Random op beats, not counting no-op codes.
  localparam int RAND_ITEMS = 1760;
  // No idling over the final stretch of the random part.
  localparam int CALM_TAIL  = 200;
  // Result is registered; a refilling pop also waits on the store read.
  localparam int DRAIN_CYCLES = 16;

  // Kind codes the package leaves unnamed: both are no-ops.
  localparam logic [2:0] KIND_NOP_6 = 3'd6;
  localparam logic [2:0] KIND_NOP_7 = 3'd7;

  // Packed order: push_dropped, is_empty, entry_count, back, front, popped_ok, popped_value.
  localparam deq_res_t RES_EMPTY = '{1'b0, 1'b1, 5'd0, WORD_NONE, WORD_NONE, 1'b0, WORD_NONE};
  localparam deq_res_t RES_ONE   = '{1'b0, 1'b0, 5'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     1'b0, WORD_NONE};
  localparam deq_res_t RES_TWO   = '{1'b0, 1'b0, 5'd2, 32'h8000_0000, 32'h7FFF_FFFF,
                                     1'b0, WORD_NONE};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;   // [31:0] value, [39:32] zero pad
  logic [2:0]   in_tuser = '0;   // [2:0] kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;       // [31:0] popped_value, [32] popped_ok,
                                 // [64:33] front_value, [96:65] back_value,
                                 // [101:97] entry_count, [102] is_empty,
                                 // [103] push_dropped

  double_ended_queue_unit #(.DEPTH(QDEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Generous fixed limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the ring, head slot, count and direction.
  // ---------------------------------------------------------------------------
  logic [31:0] ring [QDEPTH];
  int          head_slot = 0;
  int          held = 0;
  bit          flipped = 1'b0;

  deq_res_t    pending_res [$];   // results still owed by the DUT, oldest first
  int          errors = 0;

  // Idle control shared by both sides; odds are 1 in (idle_odds + 1) per beat.
  bit          idle_on = 1'b0;
  int          idle_odds = 4;

  // Apply one op to the predictor and return the status it reports.
  function automatic deq_res_t deque_step(input logic [2:0] kind, input logic [31:0] value);
    deq_res_t r;
    logic [31:0] hw, tw;
    r = '0;
    r.popped_value = WORD_NONE;
    r.front_value  = WORD_NONE;
    r.back_value   = WORD_NONE;
    case (kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (held >= QDEPTH) begin
          r.push_dropped = 1'b1;
        end else if ((kind == KIND_PUSH_FRONT) != flipped) begin
          // logical end maps onto the physical head side
          head_slot = (head_slot + QDEPTH - 1) % QDEPTH;
          ring[head_slot] = value;
          held++;
        end else begin
          ring[(head_slot + held) % QDEPTH] = value;
          held++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (held != 0) begin
          r.popped_ok = 1'b1;
          if ((kind == KIND_POP_FRONT) != flipped) begin
            r.popped_value = ring[head_slot];
            head_slot = (head_slot + 1) % QDEPTH;
          end else begin
            r.popped_value = ring[(head_slot + held - 1) % QDEPTH];
          end
          held--;
        end
      end
      KIND_CLEAR:   held = 0;            // head and direction survive a clear
      KIND_REVERSE: flipped = !flipped;
      default: ;                         // codes 6 and 7: status only
    endcase
    if (held != 0) begin
      hw = ring[head_slot];
      tw = ring[(head_slot + held - 1) % QDEPTH];
      r.front_value = flipped ? tw : hw;
      r.back_value  = flipped ? hw : tw;
    end
    r.entry_count = held[4:0];
    r.is_empty    = (held == 0);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s: expected %h, got %h", name, want, got));
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one op beat per call, optional idle burst before it.
  // The expectation is queued at the edge where the beat is taken.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [2:0] kind, input logic [31:0] value,
                         input bit typed, input deq_res_t typed_res);
    deq_res_t guess;
    if (idle_on && $urandom_range(0, idle_odds) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {8'h00, value};
    do @(posedge clk); while (!in_tready);
    guess = deque_step(kind, value);
    if (typed) guess = typed_res;
    pending_res = {pending_res, guess};
  endtask

  // Output side: random stall bursts while idling is on.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, idle_odds) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker: every accepted beat is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    deq_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = deq_res_t'(out_tdata);
      if (pending_res.size() == 0) begin
        flag_error($sformatf("result beat with nothing pending: %h", out_tdata));
      end else begin
        want = pending_res[0];
        pending_res.delete(0);
        check_field("popped_value", got.popped_value, want.popped_value);
        check_field("popped_ok",    32'(got.popped_ok),    32'(want.popped_ok));
        check_field("front_value",  got.front_value,  want.front_value);
        check_field("back_value",   got.back_value,   want.back_value);
        check_field("entry_count",  32'(got.entry_count),  32'(want.entry_count));
        check_field("is_empty",     32'(got.is_empty),     32'(want.is_empty));
        check_field("push_dropped", 32'(got.push_dropped), 32'(want.push_dropped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: kind, value (incremented per repeat), repeats, typed flag,
  // typed result. Untyped rows go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    int          reps;
    bit          typed;
    deq_res_t    want;
  } op_row_t;

  localparam int NPLAN = 26;
  op_row_t plan [NPLAN] = '{
    '{KIND_POP_FRONT,  32'h0000_0000, 1,  1'b1, RES_EMPTY},  // pop from empty
    '{KIND_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1, RES_EMPTY},
    '{KIND_REVERSE,    32'h0000_0000, 1,  1'b1, RES_EMPTY},  // reverse of empty queue
    '{KIND_REVERSE,    32'h0000_0000, 1,  1'b1, RES_EMPTY},
    '{KIND_NOP_6,      32'hDEAD_BEEF, 1,  1'b1, RES_EMPTY},  // unused code
    '{KIND_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1'b1, RES_ONE},    // max positive
    '{KIND_PUSH_BACK,  32'h8000_0000, 1,  1'b1, RES_TWO},    // min negative
    '{KIND_PUSH_BACK,  32'hFFFF_FFFF, 1,  1'b0, RES_EMPTY},  // same bits as the empty marker
    '{KIND_PUSH_FRONT, 32'h0000_0000, 1,  1'b0, RES_EMPTY},
    '{KIND_POP_FRONT,  32'h0000_0000, 1,  1'b0, RES_EMPTY},  // refilling pop
    '{KIND_REVERSE,    32'h0000_0000, 1,  1'b0, RES_EMPTY},
    '{KIND_POP_FRONT,  32'h0000_0000, 1,  1'b0, RES_EMPTY},
    '{KIND_PUSH_FRONT, 32'h1234_5678, 1,  1'b0, RES_EMPTY},
    '{KIND_PUSH_BACK,  32'hA5A5_A5A5, 1,  1'b0, RES_EMPTY},
    '{KIND_POP_BACK,   32'h0000_0000, 1,  1'b0, RES_EMPTY},
    '{KIND_NOP_7,      32'h5555_AAAA, 1,  1'b0, RES_EMPTY},
    '{KIND_CLEAR,      32'h0000_0000, 1,  1'b1, RES_EMPTY},
    '{KIND_PUSH_BACK,  32'h5A5A_5A50, 16, 1'b0, RES_EMPTY},  // fill to the brim, reversed
    '{KIND_PUSH_FRONT, 32'h0000_0001, 1,  1'b0, RES_EMPTY},  // dropped, full
    '{KIND_PUSH_BACK,  32'h0000_0002, 1,  1'b0, RES_EMPTY},  // dropped, full
    '{KIND_REVERSE,    32'h0000_0000, 1,  1'b0, RES_EMPTY},  // back to normal direction
    '{KIND_PUSH_FRONT, 32'h0000_0003, 1,  1'b0, RES_EMPTY},  // dropped, full
    '{KIND_POP_BACK,   32'h0000_0000, 8,  1'b0, RES_EMPTY},
    '{KIND_POP_FRONT,  32'h0000_0000, 8,  1'b0, RES_EMPTY},  // drain to empty
    '{KIND_POP_FRONT,  32'h0000_0000, 1,  1'b1, RES_EMPTY},  // empty pop
    '{KIND_REVERSE,    32'h0000_0000, 1,  1'b0, RES_EMPTY}
  };

  initial begin : stimulus
    logic [2:0]  kind;
    logic [31:0] value;
    int          useful;
    int          issued;
    int          push_pct;
    int          pick;

    // synchronous reset, held low from the start, then released
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on   = 1'b1;
    idle_odds = 4;
    foreach (plan[i]) begin
      for (int r = 0; r < plan[i].reps; r++)
        send_op(plan[i].kind, plan[i].value + r, plan[i].typed, plan[i].want);
    end

    // Random part. Every 64 beats a new mood: fill, drain or balanced, plus
    // a new idle density (sometimes none) until the calm tail.
    useful   = 0;
    issued   = 0;
    push_pct = 50;
    while (useful < RAND_ITEMS) begin
      if (issued % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
        pick = $urandom_range(0, 3);
        idle_on = (pick != 0);
        idle_odds = (pick == 1) ? 2 : (pick == 2) ? 6 : 15;
      end
      if (useful >= RAND_ITEMS - CALM_TAIL) idle_on = 1'b0;

      pick = $urandom_range(0, 99);
      if (pick < 2)
        kind = $urandom_range(0, 1) ? KIND_NOP_7 : KIND_NOP_6;  // noise
      else if (pick < 4)
        kind = KIND_CLEAR;
      else if (pick < 10)
        kind = KIND_REVERSE;
      else if ($urandom_range(0, 99) < push_pct)
        kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else
        kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;

      case ($urandom_range(0, 7))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = 32'hFFFF_FFFF;
        3:       value = 32'h0000_0000;
        4:       value = $urandom_range(0, 255);
        default: value = $urandom;
      endcase

      send_op(kind, value, 1'b0, RES_EMPTY);
      issued++;
      if (kind != KIND_NOP_6 && kind != KIND_NOP_7) useful++;
    end

    // Drain: wait for every owed beat, then keep watching for strays.
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_res.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_res.size()));

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
